@@ rtl/core/nsfr_pkg.sv @@
// Shared constants and types for the navigation solution frame receiver.
package nsfr_pkg;

    localparam int FRAME_BYTES  = 60;
    localparam int POS_W        = 6;
    localparam int FIX_TYPE_POS = 16;
    localparam int DATA_FIRST   = 18;
    localparam int DATA_BYTES   = 32;
    localparam int DATA_WORDS   = DATA_BYTES / 4;
    localparam int SUM_FIRST    = 2;
    localparam int SUM_LAST     = FRAME_BYTES - 3;
    localparam int CSUM_A_POS   = FRAME_BYTES - 2;
    localparam int HEADER_LEN   = 4;

    localparam logic [7:0] MIN_FIX_RESET = 8'd3;

    localparam logic [7:0] HDR_SYNC1 = 8'hB5;
    localparam logic [7:0] HDR_SYNC2 = 8'h62;
    localparam logic [7:0] HDR_CLASS = 8'h01;
    localparam logic [7:0] HDR_ID    = 8'h06;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_CSUM_ERR  = 2'd1,
        ST_BUSY_DROP = 2'd2
    } nsfr_status_t;

    typedef struct packed {
        nsfr_status_t status;
        logic         fix_valid;
        logic [31:0]  pos_x_cm;
        logic [31:0]  pos_y_cm;
        logic [31:0]  pos_z_cm;
        logic [31:0]  pos_accuracy_cm;
        logic [31:0]  vel_x_cms;
        logic [31:0]  vel_y_cms;
        logic [31:0]  vel_z_cms;
        logic [31:0]  vel_accuracy_cms;
    } nsfr_result_t;

    typedef struct packed {
        logic         valid;
        logic         last;
        nsfr_result_t result;
    } nsfr_parse_t;

    function automatic logic [7:0] header_byte(input logic [1:0] idx);
        logic [7:0] hb;
        case (idx)
            2'd0:    hb = HDR_SYNC1;
            2'd1:    hb = HDR_SYNC2;
            2'd2:    hb = HDR_CLASS;
            2'd3:    hb = HDR_ID;
            default: hb = HDR_SYNC1;
        endcase
        return hb;
    endfunction

endpackage

@@ rtl/core/nsfr_parser.sv @@
// Frame position tracker, header check, Fletcher sum and field capture.
module nsfr_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    input  logic                 reader_busy,
    input  logic [7:0]           min_fix_type,
    output nsfr_pkg::nsfr_parse_t parse
);
    import nsfr_pkg::*;

    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_HDR    = POS_W'(HEADER_LEN);
    localparam logic [POS_W-1:0] POS_SUM_LO = POS_W'(SUM_FIRST);
    localparam logic [POS_W-1:0] POS_SUM_HI = POS_W'(SUM_LAST);
    localparam logic [POS_W-1:0] POS_FIX    = POS_W'(FIX_TYPE_POS);
    localparam logic [POS_W-1:0] POS_CSUM_A = POS_W'(CSUM_A_POS);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_a_reg, sum_a_next;
    logic [7:0]       sum_b_reg, sum_b_next;
    logic [7:0]       fix_type_reg;
    logic [7:0]       csum_a_rx_reg;
    logic [7:0]       data_reg [DATA_BYTES];

    logic             in_range;
    logic             hdr_bad;
    logic             keep;
    logic             last;
    logic             in_sum;
    logic             csum_ok;
    logic [7:0][31:0] words;

    always_comb
    begin
        in_range = (pos_reg <= POS_LAST);
        hdr_bad  = (pos_reg < POS_HDR) && (rx_byte != header_byte(pos_reg[1:0]));
        keep     = in_range && !hdr_bad;
        last     = (pos_reg == POS_LAST);
        in_sum   = (pos_reg >= POS_SUM_LO) && (pos_reg <= POS_SUM_HI);
    end

    always_comb
    begin
        pos_next   = pos_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        if (step)
        begin
            if (!keep || last)
            begin
                pos_next   = '0;
                sum_a_next = '0;
                sum_b_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (in_sum)
                begin
                    sum_a_next = sum_a_reg + rx_byte;
                    sum_b_next = sum_b_reg + sum_a_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // Each capture byte has a fixed frame slot of its own.
    always_ff @(posedge clk)
    begin
        if (step && pos_reg == POS_FIX)
        begin
            fix_type_reg <= rx_byte;
        end
        if (step && pos_reg == POS_CSUM_A)
        begin
            csum_a_rx_reg <= rx_byte;
        end
        for (int i = 0; i < DATA_BYTES; i++)
        begin
            if (step && pos_reg == POS_W'(DATA_FIRST + i))
            begin
                data_reg[i] <= rx_byte;
            end
        end
    end

    always_comb
    begin
        for (int w = 0; w < DATA_WORDS; w++)
        begin
            words[w] = {data_reg[4*w+3], data_reg[4*w+2], data_reg[4*w+1], data_reg[4*w]};
        end
    end

    // Last byte is the received B sum; the sums already cover the payload.
    assign csum_ok = (csum_a_rx_reg == sum_a_reg) && (rx_byte == sum_b_reg);

    always_comb
    begin
        parse.valid  = step && keep && last;
        parse.last   = last;
        parse.result = '0;
        if (!csum_ok)
        begin
            parse.result.status = ST_CSUM_ERR;
        end
        else if (reader_busy)
        begin
            parse.result.status = ST_BUSY_DROP;
        end
        else
        begin
            parse.result.status           = ST_ACCEPTED;
            parse.result.fix_valid        = (fix_type_reg >= min_fix_type);
            parse.result.pos_x_cm         = words[0];
            parse.result.pos_y_cm         = words[1];
            parse.result.pos_z_cm         = words[2];
            parse.result.pos_accuracy_cm  = words[3];
            parse.result.vel_x_cms        = words[4];
            parse.result.vel_y_cms        = words[5];
            parse.result.vel_z_cms        = words[6];
            parse.result.vel_accuracy_cms = words[7];
        end
    end

endmodule

@@ rtl/core/nsfr_result_reg.sv @@
// Result register with valid/ready handshake toward the consumer.
module nsfr_result_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  nsfr_pkg::nsfr_result_t result_in,
    input  logic                  out_ready,
    output logic                  out_valid,
    output nsfr_pkg::nsfr_result_t result_out
);
    import nsfr_pkg::*;

    logic         out_valid_reg, out_valid_next;
    nsfr_result_t result_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = out_valid_reg;
    assign result_out = result_reg;

endmodule

@@ rtl/core/nav_solution_frame_receiver.sv @@
// Top level of the navigation solution frame receiver.
//
//  Channel   Handshake              Word
//  -------   ---------------------  ----------------------------------------
//  input     in_valid / in_ready    rx_byte, reader_busy (one serial byte)
//  output    out_valid / out_ready  frame_status, fix_valid, eight 32-bit fields
//  config    cfg_we                 cfg_wdata -> min_fix_type (reset 3)
//
//  One word is taken per cycle unless a last byte is held. A byte is parsed in
//  a single pass while it sits in the input register; a frame result loads into
//  the result register when the last byte of a frame advances, and out_valid is
//  driven from that register. Only the last byte of a frame waits for a free
//  result register; every other byte advances without regard to out_ready.
//  Reset (rst_n, async, active low) clears the position, the sums, the valid
//  flags and sets min_fix_type to 3; captured payload bytes are not reset.
module nav_solution_frame_receiver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               reader_busy,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         frame_status,
    output logic               fix_valid,
    output logic signed [31:0] pos_x_cm,
    output logic signed [31:0] pos_y_cm,
    output logic signed [31:0] pos_z_cm,
    output logic [31:0]        pos_accuracy_cm,
    output logic signed [31:0] vel_x_cms,
    output logic signed [31:0] vel_y_cms,
    output logic signed [31:0] vel_z_cms,
    output logic [31:0]        vel_accuracy_cms
);
    import nsfr_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   byte_reg;
    logic         busy_reg;
    logic [7:0]   min_fix_type_reg;
    logic         advance;
    logic         take;
    logic         out_valid_int;
    nsfr_parse_t  parse;
    nsfr_result_t result;

    // Hold a last byte until the result register can take its result.
    assign advance  = in_valid_reg && (!parse.last || !out_valid_int || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            min_fix_type_reg <= MIN_FIX_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_we)
            begin
                min_fix_type_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx_byte;
            busy_reg <= reader_busy;
        end
    end

    nsfr_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .rx_byte      (byte_reg),
        .reader_busy  (busy_reg),
        .min_fix_type (min_fix_type_reg),
        .parse        (parse)
    );

    nsfr_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (parse.valid),
        .result_in  (parse.result),
        .out_ready  (out_ready),
        .out_valid  (out_valid_int),
        .result_out (result)
    );

    assign out_valid        = out_valid_int;
    assign frame_status     = result.status;
    assign fix_valid        = result.fix_valid;
    assign pos_x_cm         = result.pos_x_cm;
    assign pos_y_cm         = result.pos_y_cm;
    assign pos_z_cm         = result.pos_z_cm;
    assign pos_accuracy_cm  = result.pos_accuracy_cm;
    assign vel_x_cms        = result.vel_x_cms;
    assign vel_y_cms        = result.vel_y_cms;
    assign vel_z_cms        = result.vel_z_cms;
    assign vel_accuracy_cms = result.vel_accuracy_cms;

endmodule
